@@ design/fees_pkg.sv @@
// Shared types and constants for the flash EEPROM emulation store.
// Used by the top level and the result generator; no dependencies.
`default_nettype none

package fees_pkg;

  // Input commands
  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_REC_WR = 2'd2;
  localparam logic [1:0] CMD_REC_RD = 2'd3;

  // Result kinds
  localparam logic [2:0] K_DATA    = 3'd0;
  localparam logic [2:0] K_SAME    = 3'd1;
  localparam logic [2:0] K_ERASE   = 3'd2;
  localparam logic [2:0] K_ROW     = 3'd3;
  localparam logic [2:0] K_VERDICT = 3'd4;
  localparam logic [2:0] K_DROP    = 3'd5;

  localparam logic [11:0] INDEX_MAX = 12'd4095;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] address;
    logic [11:0] length;
    logic [7:0]  data;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] row;
    logic [7:0] read_data;
    logic       checksum_ok;
    logic       end_of_run;
  } out_item_t;

  // What the result generator emits for one item
  typedef struct packed {
    logic       head_en;    // one leading data/same/drop result
    logic [2:0] head_kind;
    logic [7:0] head_data;
    logic       verd_en;    // verdict after the head
    logic       ok;
    logic [1:0] ncommit;    // erase + row runs that follow
  } plan_t;

  // Rotate left by one, then add
  function automatic logic [7:0] mix(input logic [7:0] cs, input logic [7:0] b);
    logic [7:0] rot;
    rot = {cs[6:0], cs[7]};
    return rot + b;
  endfunction

endpackage

`default_nettype wire

@@ design/fees_result_gen.sv @@
// Result sequencer and output register for the flash EEPROM emulation store.
// Depends on fees_pkg (plan_t, out_item_t, result kinds).
`default_nettype none

module fees_result_gen #(
  parameter int ROW_RESULTS = 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  fees_pkg::plan_t      plan,
  output logic                 busy,
  output logic                 out_valid,
  input  wire                  out_ready,
  output fees_pkg::out_item_t  out_data
);

  typedef enum logic [4:0] {
    G_IDLE  = 5'b00001,
    G_HEAD  = 5'b00010,
    G_VERD  = 5'b00100,
    G_ERASE = 5'b01000,
    G_ROW   = 5'b10000
  } gstate_t;

  gstate_t             state_r, state_nxt;
  fees_pkg::plan_t     plan_r, plan_nxt;
  logic [1:0]          ncommit_r, ncommit_nxt;
  logic [2:0]          row_r, row_nxt;
  logic                out_valid_r, out_valid_nxt;
  fees_pkg::out_item_t out_data_r, out_data_nxt;
  logic                can_emit;
  logic                last_row;

  assign can_emit = !out_valid_r || out_ready;
  assign last_row = ({1'b0, row_r} == 4'(ROW_RESULTS - 1));
  assign busy      = (state_r != G_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    plan_nxt      = plan_r;
    ncommit_nxt   = ncommit_r;
    row_nxt       = row_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      G_IDLE: begin
        if (start) begin
          plan_nxt    = plan;
          ncommit_nxt = plan.ncommit;
          state_nxt   = plan.head_en ? G_HEAD : G_ERASE;
        end
      end
      G_HEAD: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: plan_r.head_kind, row: 3'd0, read_data: plan_r.head_data,
                            checksum_ok: 1'b0,
                            end_of_run: !plan_r.verd_en && (ncommit_r == 2'd0)};
          if (plan_r.verd_en)          state_nxt = G_VERD;
          else if (ncommit_r != 2'd0)  state_nxt = G_ERASE;
          else                         state_nxt = G_IDLE;
        end
      end
      G_VERD: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: fees_pkg::K_VERDICT, row: 3'd0, read_data: 8'd0,
                            checksum_ok: plan_r.ok, end_of_run: 1'b1};
          state_nxt     = G_IDLE;
        end
      end
      G_ERASE: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: fees_pkg::K_ERASE, row: 3'd0, read_data: 8'd0,
                            checksum_ok: 1'b0,
                            end_of_run: (ROW_RESULTS == 0) && (ncommit_r == 2'd1)};
          row_nxt = 3'd0;
          if (ROW_RESULTS != 0) begin
            state_nxt = G_ROW;
          end else begin
            ncommit_nxt = ncommit_r - 2'd1;
            state_nxt   = (ncommit_r == 2'd1) ? G_IDLE : G_ERASE;
          end
        end
      end
      G_ROW: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: fees_pkg::K_ROW, row: row_r, read_data: 8'd0,
                            checksum_ok: 1'b0, end_of_run: last_row && (ncommit_r == 2'd1)};
          if (last_row) begin
            ncommit_nxt = ncommit_r - 2'd1;
            state_nxt   = (ncommit_r == 2'd1) ? G_IDLE : G_ERASE;
          end else begin
            row_nxt = row_r + 3'd1;
          end
        end
      end
      default: state_nxt = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= G_IDLE;
      ncommit_r   <= 2'd0;
      row_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ncommit_r   <= ncommit_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plan_r     <= plan_nxt;
    out_data_r <= out_data_nxt;
  end

  a_erase_has_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == G_ERASE |-> ncommit_r != 2'd0)
    else $error("erase run with no commit pending");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == G_ROW |-> {1'b0, row_r} < 4'(ROW_RESULTS))
    else $error("row index past row count");

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == G_IDLE)
    else $error("new plan while results still pending");

endmodule

`default_nettype wire

@@ design/flash_eeprom_emulation_store.sv @@
// Top level of the flash EEPROM emulation store: byte store memory and command FSM.
// Depends on fees_pkg and fees_result_gen.
`default_nettype none

// Byte store kept in one single-port synchronous memory (min(STORE_BYTES, PAGE_BYTES)
// bytes, registered read). After reset a clearing pass writes 0xFF to every
// byte, one per cycle; no item is taken until it ends. One item is handled at a
// time and its steps are set by the memory port: a record write byte that is not
// the last is a read, then a write back; byte reads, byte writes and record read
// bytes are a read, a plan, a hand-off to the result sequencer and its return to
// idle; the last item of a record adds the checksum byte access.
// Results leave through an output register, one per cycle while the receiver is ready;
// a commit is one erase plus one result per row, at most 8 rows, and each result and
// every receiver hold-off lengthen the item.
// The next item is accepted while the final result still waits in the output register.
module flash_eeprom_emulation_store #(
  parameter int STORE_BYTES = 1024,
  parameter int PAGE_BYTES  = 2048,
  parameter int ROW_BYTES   = 256
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  fees_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output fees_pkg::out_item_t  out_data
);

  localparam int STORE_LIMIT = (STORE_BYTES < PAGE_BYTES) ? STORE_BYTES : PAGE_BYTES;
  localparam int ROW_COUNT   = PAGE_BYTES / ROW_BYTES;
  localparam int ROW_RESULTS = (ROW_COUNT > 8) ? 8 : ROW_COUNT;
  localparam int AW          = $clog2(STORE_LIMIT);
  localparam logic [12:0] LIMIT13 = 13'(STORE_LIMIT);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD1   = 6'b000100,
    S_CKRD  = 6'b001000,
    S_CK    = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;

  logic [1:0]      cmd_r, cmd_nxt;
  logic [11:0]     addr_r, addr_nxt;
  logic [11:0]     len_r, len_nxt;
  logic [7:0]      data_r, data_nxt;
  logic            last_r, last_nxt;
  logic [AW-1:0]   pa_r, pa_nxt;
  logic            pinr_r, pinr_nxt;
  logic [AW-1:0]   ck_addr_r, ck_addr_nxt;
  logic            ck_inr_r, ck_inr_nxt;

  logic [11:0]     idx_r, idx_nxt;
  logic [7:0]      cs_r, cs_nxt;
  logic            dirty_r, dirty_nxt;
  logic            dropped_r, dropped_nxt;
  logic            active_r, active_nxt;

  fees_pkg::plan_t plan_r, plan_nxt;
  logic            start_r, start_nxt;
  logic            gen_busy;

  // memory port
  logic [7:0]      mem [STORE_LIMIT];
  logic [7:0]      mem_q_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_addr;
  logic [7:0]      mem_wd;

  logic            is_rec;
  logic [12:0]     eff;
  logic [12:0]     rec_end;
  logic [12:0]     ck_sum;
  logic            range_bad;
  logic            drop_now;
  logic [7:0]      byte_v;
  logic [7:0]      ck_byte;
  logic [11:0]     idx_bump;
  logic            chk_chg;

  assign in_ready = (state_r == S_IDLE);
  assign is_rec   = (in_data.command == fees_pkg::CMD_REC_WR) ||
                    (in_data.command == fees_pkg::CMD_REC_RD);
  assign eff      = {1'b0, in_data.address} + (is_rec ? {1'b0, idx_r} : 13'd0);
  assign rec_end  = {1'b0, in_data.address} + {1'b0, in_data.length} + 13'd1;
  assign range_bad = ({1'b0, in_data.address} >= LIMIT13) ||
                     ({1'b0, in_data.length} >= LIMIT13) || (rec_end > LIMIT13);
  assign drop_now = (idx_r == 12'd0) ? range_bad : dropped_r;
  assign byte_v   = pinr_r ? mem_q_r : 8'hFF;
  assign ck_byte  = ck_inr_r ? mem_q_r : 8'hFF;
  assign idx_bump = (idx_r < fees_pkg::INDEX_MAX) ? idx_r + 12'd1 : idx_r;
  assign ck_sum   = {1'b0, addr_r} +
                    ((cmd_r == fees_pkg::CMD_REC_WR) ? {1'b0, len_r} : {1'b0, idx_r});
  assign chk_chg  = ck_inr_r && (mem_q_r != cs_r);

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    cmd_nxt     = cmd_r;
    addr_nxt    = addr_r;
    len_nxt     = len_r;
    data_nxt    = data_r;
    last_nxt    = last_r;
    pa_nxt      = pa_r;
    pinr_nxt    = pinr_r;
    ck_addr_nxt = ck_addr_r;
    ck_inr_nxt  = ck_inr_r;
    idx_nxt     = idx_r;
    cs_nxt      = cs_r;
    dirty_nxt   = dirty_r;
    dropped_nxt = dropped_r;
    active_nxt  = active_r;
    plan_nxt    = plan_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = pa_r;
    mem_wd      = data_r;

    case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        mem_wd   = 8'hFF;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == AW'(STORE_LIMIT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt  = in_data.command;
          addr_nxt = in_data.address;
          len_nxt  = in_data.length;
          data_nxt = in_data.data;
          last_nxt = in_data.last;
          pa_nxt   = eff[AW-1:0];
          pinr_nxt = (eff < LIMIT13);
          mem_addr = eff[AW-1:0];
          mem_re   = (eff < LIMIT13);
          if (in_data.command == fees_pkg::CMD_REC_WR) begin
            dropped_nxt = drop_now;
            active_nxt  = !drop_now && (idx_r < in_data.length);
            if (idx_r == 12'd0) begin
              cs_nxt    = 8'd0;
              dirty_nxt = 1'b0;
            end
          end else if (in_data.command == fees_pkg::CMD_REC_RD) begin
            if (idx_r == 12'd0) cs_nxt = 8'd0;
          end
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        plan_nxt = '0;
        case (cmd_r)
          fees_pkg::CMD_READ: begin
            plan_nxt.head_en   = 1'b1;
            plan_nxt.head_kind = fees_pkg::K_DATA;
            plan_nxt.head_data = byte_v;
            state_nxt          = S_EMIT;
          end
          fees_pkg::CMD_WRITE: begin
            if (pinr_r && (mem_q_r != data_r)) begin
              mem_we           = 1'b1;
              plan_nxt.ncommit = 2'd1;
            end else begin
              plan_nxt.head_en   = 1'b1;
              plan_nxt.head_kind = fees_pkg::K_SAME;
            end
            state_nxt = S_EMIT;
          end
          fees_pkg::CMD_REC_WR: begin
            if (active_r) begin
              cs_nxt = fees_pkg::mix(cs_r, data_r);
              if (pinr_r && (mem_q_r != data_r)) begin
                mem_we    = 1'b1;
                dirty_nxt = 1'b1;
              end
            end
            idx_nxt = idx_bump;
            if (!last_r) begin
              state_nxt = S_IDLE;  // no result until the last byte
            end else if (dropped_r) begin
              plan_nxt.head_en   = 1'b1;
              plan_nxt.head_kind = fees_pkg::K_DROP;
              idx_nxt     = 12'd0;
              cs_nxt      = 8'd0;
              dirty_nxt   = 1'b0;
              dropped_nxt = 1'b0;
              state_nxt   = S_EMIT;
            end else begin
              state_nxt = S_CKRD;
            end
          end
          default: begin  // record read
            cs_nxt             = fees_pkg::mix(cs_r, byte_v);
            plan_nxt.head_en   = 1'b1;
            plan_nxt.head_kind = fees_pkg::K_DATA;
            plan_nxt.head_data = byte_v;
            idx_nxt            = idx_bump;
            state_nxt          = last_r ? S_CKRD : S_EMIT;
          end
        endcase
      end
      S_CKRD: begin
        // checksum byte: after the record for writes, at the new index for reads
        ck_addr_nxt = ck_sum[AW-1:0];
        ck_inr_nxt  = (ck_sum < LIMIT13);
        mem_addr    = ck_sum[AW-1:0];
        mem_re      = (ck_sum < LIMIT13);
        state_nxt   = S_CK;
      end
      S_CK: begin
        mem_addr = ck_addr_r;
        mem_wd   = cs_r;
        if (cmd_r == fees_pkg::CMD_REC_WR) begin
          mem_we           = chk_chg;
          plan_nxt.ncommit = {1'b0, dirty_r} + {1'b0, chk_chg};
          if (!dirty_r && !chk_chg) begin
            plan_nxt.head_en   = 1'b1;
            plan_nxt.head_kind = fees_pkg::K_SAME;
          end
        end else begin
          plan_nxt.verd_en = 1'b1;
          plan_nxt.ok      = (ck_byte == cs_r);
        end
        idx_nxt     = 12'd0;
        cs_nxt      = 8'd0;
        dirty_nxt   = 1'b0;
        dropped_nxt = 1'b0;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (!start_r && !gen_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign start_nxt = (state_nxt == S_EMIT) && (state_r != S_EMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      idx_r     <= 12'd0;
      cs_r      <= 8'd0;
      dirty_r   <= 1'b0;
      dropped_r <= 1'b0;
      start_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      idx_r     <= idx_nxt;
      cs_r      <= cs_nxt;
      dirty_r   <= dirty_nxt;
      dropped_r <= dropped_nxt;
      start_r   <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    addr_r    <= addr_nxt;
    len_r     <= len_nxt;
    data_r    <= data_nxt;
    last_r    <= last_nxt;
    pa_r      <= pa_nxt;
    pinr_r    <= pinr_nxt;
    ck_addr_r <= ck_addr_nxt;
    ck_inr_r  <= ck_inr_nxt;
    active_r  <= active_nxt;
    plan_r    <= plan_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    if (mem_re) mem_q_r <= mem[mem_addr];
  end

  fees_result_gen #(
    .ROW_RESULTS (ROW_RESULTS)
  ) u_result_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .plan      (plan_r),
    .busy      (gen_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !mem_we)
    else $error("memory write while idle");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_RD1)
    else $error("accepted transfer not followed by memory read");

  a_start_gen_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> !gen_busy)
    else $error("result plan issued while generator busy");

  a_record_closed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CK |=> (idx_r == 12'd0) && (cs_r == 8'd0) && !dirty_r)
    else $error("record state not cleared after last byte");

endmodule

`default_nettype wire

@@ tb/sv/flash_eeprom_emulation_store_tb.sv @@
// Self-checking testbench for flash_eeprom_emulation_store: directed and random
// byte/record traffic, result-by-result comparison against an in-bench store image.
// Depends on fees_pkg and the design top level.
module flash_eeprom_emulation_store_tb;

  localparam int STORE_BYTES = 1024;
  localparam int PAGE_BYTES = 2048;
  localparam int ROW_BYTES = 256;
  localparam int STORE_LIM = (STORE_BYTES < PAGE_BYTES) ? STORE_BYTES : PAGE_BYTES;
  localparam int ROW_RUNS = (PAGE_BYTES / ROW_BYTES > 8) ? 8 : PAGE_BYTES / ROW_BYTES;
  localparam int HOLD_CYCLES = 400;
  localparam int TIMEOUT_CYCLES = 800000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fees_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fees_pkg::out_item_t out_data;

  flash_eeprom_emulation_store #(
    .STORE_BYTES(STORE_BYTES),
    .PAGE_BYTES(PAGE_BYTES),
    .ROW_BYTES(ROW_BYTES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Store image and record state as the block should hold them
  logic [7:0] flash_img [0:STORE_LIM-1];
  logic [7:0] rec_sum = '0;
  int rec_pos = 0;
  bit rec_changed = 1'b0;
  bit rec_skip = 1'b0;

  fees_pkg::in_item_t pending_items[$];
  fees_pkg::out_item_t awaited_results[$];
  fees_pkg::out_item_t run_buf[$];
  fees_pkg::out_item_t want_res;
  int rec_starts[$];
  int rec_lens[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit pressure_phase = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;

  int err_count = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int erase_seen = 0;
  int verdict_seen = 0;
  int drop_seen = 0;

  function automatic logic [7:0] fold_byte(input logic [7:0] s, input logic [7:0] b);
    return ((s << 1) | (s >> 7)) + b;
  endfunction

  function automatic logic [7:0] byte_at(input int a);
    return (a >= STORE_LIM) ? 8'hFF : flash_img[a];
  endfunction

  // Wear guard: only a real change touches the image
  function automatic bit store_byte(input int a, input logic [7:0] v);
    if (a >= STORE_LIM || flash_img[a] == v) return 1'b0;
    flash_img[a] = v;
    return 1'b1;
  endfunction

  function automatic fees_pkg::out_item_t result_of(input logic [2:0] k, input logic [2:0] r,
                                                    input logic [7:0] d, input logic ok);
    fees_pkg::out_item_t res;
    res = '0;
    res.kind = k;
    res.row = r;
    res.read_data = d;
    res.checksum_ok = ok;
    return res;
  endfunction

  function automatic void add_commit();
    run_buf.push_back(result_of(fees_pkg::K_ERASE, 3'd0, 8'h00, 1'b0));
    for (int r = 0; r < ROW_RUNS; r++) begin
      run_buf.push_back(result_of(fees_pkg::K_ROW, r[2:0], 8'h00, 1'b0));
    end
  endfunction

  function automatic void reset_record();
    rec_pos = 0;
    rec_sum = '0;
    rec_changed = 1'b0;
    rec_skip = 1'b0;
  endfunction

  task automatic predict_store_reply(input fees_pkg::in_item_t it);
    int a;
    int l;
    logic [7:0] b;
    a = int'(it.address);
    l = int'(it.length);
    run_buf.delete();
    case (it.command)
      fees_pkg::CMD_READ: begin
        run_buf.push_back(result_of(fees_pkg::K_DATA, 3'd0, byte_at(a), 1'b0));
      end
      fees_pkg::CMD_WRITE: begin
        if (store_byte(a, it.data)) add_commit();
        else run_buf.push_back(result_of(fees_pkg::K_SAME, 3'd0, 8'h00, 1'b0));
      end
      fees_pkg::CMD_REC_WR: begin
        if (rec_pos == 0) begin
          rec_sum = '0;
          rec_changed = 1'b0;
          rec_skip = (a >= STORE_LIM) || (l >= STORE_LIM) || (a + l + 1 > STORE_LIM);
        end
        if (!rec_skip && rec_pos < l) begin
          rec_sum = fold_byte(rec_sum, it.data);
          if (store_byte(a + rec_pos, it.data)) rec_changed = 1'b1;
        end
        if (rec_pos < int'(fees_pkg::INDEX_MAX)) rec_pos++;
        if (it.last) begin
          if (rec_skip) begin
            run_buf.push_back(result_of(fees_pkg::K_DROP, 3'd0, 8'h00, 1'b0));
          end else begin
            if (rec_changed) add_commit();
            // checksum byte sits right after the record
            if (store_byte(a + l, rec_sum)) add_commit();
            if (run_buf.size() == 0) begin
              run_buf.push_back(result_of(fees_pkg::K_SAME, 3'd0, 8'h00, 1'b0));
            end
          end
          reset_record();
        end
      end
      default: begin
        if (rec_pos == 0) rec_sum = '0;
        b = byte_at(a + rec_pos);
        rec_sum = fold_byte(rec_sum, b);
        run_buf.push_back(result_of(fees_pkg::K_DATA, 3'd0, b, 1'b0));
        if (rec_pos < int'(fees_pkg::INDEX_MAX)) rec_pos++;
        if (it.last) begin
          run_buf.push_back(result_of(fees_pkg::K_VERDICT, 3'd0, 8'h00,
                                      byte_at(a + rec_pos) == rec_sum));
          reset_record();
        end
      end
    endcase
    // record write bytes before the last give no results
    if (run_buf.size() > 0) run_buf[run_buf.size()-1].end_of_run = 1'b1;
    foreach (run_buf[i]) awaited_results.push_back(run_buf[i]);
  endtask

  function automatic void queue_item(input logic [1:0] cmd, input int a, input int l,
                                     input logic [7:0] d, input bit lst);
    fees_pkg::in_item_t it;
    it.command = cmd;
    it.address = a[11:0];
    it.length = l[11:0];
    it.data = d;
    it.last = lst;
    pending_items.push_back(it);
  endfunction

  // Mostly inside the store, now and then anywhere in the 12-bit range
  function automatic int near_addr();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, STORE_LIM - 1);
  endfunction

  task automatic queue_random(input int target);
    int added;
    int r;
    int a;
    int l;
    int n;
    int k;
    logic [7:0] d;
    added = 0;
    while (added < target) begin
      r = $urandom_range(0, 99);
      if (r < 18) begin
        queue_item(fees_pkg::CMD_READ, near_addr(), $urandom_range(0, 4095), 8'($urandom),
                   1'($urandom_range(0, 1)));
        added++;
      end else if (r < 38) begin
        k = $urandom_range(0, 3);
        d = (k == 0) ? 8'hFF : (k == 1) ? 8'h00 : 8'($urandom);
        queue_item(fees_pkg::CMD_WRITE, near_addr(), $urandom_range(0, 4095), d,
                   1'($urandom_range(0, 1)));
        added++;
      end else if (r < 68) begin
        l = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
        if ($urandom_range(0, 9) == 0) a = $urandom_range(STORE_LIM - l, 4095);
        else a = $urandom_range(0, STORE_LIM - 1 - l);
        k = $urandom_range(0, 5);
        n = l;
        if (k == 0) n = l + $urandom_range(1, 2);
        else if (k == 1 && l > 1) n = l - 1;
        if (n == 0) n = 1;
        for (int i = 0; i < n; i++) begin
          queue_item(fees_pkg::CMD_REC_WR, a, l, 8'($urandom), i == n - 1);
        end
        if (a + l < STORE_LIM) begin
          rec_starts.push_back(a);
          rec_lens.push_back(l);
        end
        added += n;
      end else if (r < 90) begin
        if (rec_starts.size() > 0 && $urandom_range(0, 3) != 0) begin
          k = $urandom_range(0, rec_starts.size() - 1);
          a = rec_starts[k];
          n = (rec_lens[k] == 0) ? 1 : rec_lens[k];
        end else begin
          a = near_addr();
          n = $urandom_range(1, 6);
        end
        for (int i = 0; i < n; i++) begin
          queue_item(fees_pkg::CMD_REC_RD, a, $urandom_range(0, 4095), 8'($urandom),
                     i == n - 1);
        end
        added += n;
      end else begin
        // noise: breaks and interleaves record sequences
        queue_item(2'($urandom_range(0, 3)), $urandom_range(0, 4095), $urandom_range(0, 4095),
                   8'($urandom), 1'($urandom_range(0, 1)));
        added++;
      end
    end
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || awaited_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        items_accepted++;
        predict_store_reply(in_data);
      end
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver ready, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (pressure_phase && !hold_used) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (out_data.kind == fees_pkg::K_ERASE) erase_seen++;
      if (out_data.kind == fees_pkg::K_VERDICT) verdict_seen++;
      if (out_data.kind == fees_pkg::K_DROP) drop_seen++;
      if (awaited_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result kind=%0d row=%0d data=%02h ok=%0b eor=%0b", $time,
                 out_data.kind, out_data.row, out_data.read_data, out_data.checksum_ok,
                 out_data.end_of_run);
      end else begin
        want_res = awaited_results.pop_front();
        if (out_data.kind !== want_res.kind || out_data.row !== want_res.row ||
            out_data.read_data !== want_res.read_data ||
            out_data.checksum_ok !== want_res.checksum_ok ||
            out_data.end_of_run !== want_res.end_of_run) begin
          err_count++;
          $display("%0t: mismatch expected kind=%0d row=%0d data=%02h ok=%0b eor=%0b", $time,
                   want_res.kind, want_res.row, want_res.read_data, want_res.checksum_ok,
                   want_res.end_of_run);
          $display("%0t:          actual kind=%0d row=%0d data=%02h ok=%0b eor=%0b", $time,
                   out_data.kind, out_data.row, out_data.read_data, out_data.checksum_ok,
                   out_data.end_of_run);
        end
      end
    end
  end

  initial begin : stimulus
    foreach (flash_img[i]) flash_img[i] = 8'hFF;
    send_idle_pct = 17;
    recv_idle_pct = 77;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // erased reads, in range and past the store
    queue_item(fees_pkg::CMD_READ, 0, 0, 8'h00, 1'b0);
    queue_item(fees_pkg::CMD_READ, 4095, 4095, 8'hFF, 1'b1);
    // write, then the same value again, then a write outside the store and one to its top byte
    queue_item(fees_pkg::CMD_WRITE, 5, 0, 8'hA5, 1'b0);
    queue_item(fees_pkg::CMD_WRITE, 5, 0, 8'hA5, 1'b0);
    queue_item(fees_pkg::CMD_WRITE, 4095, 0, 8'h00, 1'b0);
    queue_item(fees_pkg::CMD_WRITE, STORE_LIM - 1, 0, 8'h00, 1'b0);
    queue_item(fees_pkg::CMD_READ, STORE_LIM - 1, 0, 8'h00, 1'b0);
    // record with a byte read in between: staged byte must already show
    queue_item(fees_pkg::CMD_REC_WR, 100, 2, 8'h81, 1'b0);
    queue_item(fees_pkg::CMD_READ, 100, 0, 8'h00, 1'b0);
    queue_item(fees_pkg::CMD_REC_WR, 100, 2, 8'hFF, 1'b1);
    queue_item(fees_pkg::CMD_REC_RD, 100, 2, 8'h00, 1'b0);
    queue_item(fees_pkg::CMD_REC_RD, 100, 2, 8'h00, 1'b1);
    // same record again: nothing changes
    queue_item(fees_pkg::CMD_REC_WR, 100, 2, 8'h81, 1'b0);
    queue_item(fees_pkg::CMD_REC_WR, 100, 2, 8'hFF, 1'b1);
    // out-of-range records get dropped
    queue_item(fees_pkg::CMD_REC_WR, STORE_LIM - 24, 30, 8'h11, 1'b1);
    queue_item(fees_pkg::CMD_REC_WR, 4095, 0, 8'h22, 1'b1);
    queue_item(fees_pkg::CMD_REC_WR, 0, 4095, 8'h33, 1'b1);
    // zero-length record: only the checksum lands
    queue_item(fees_pkg::CMD_REC_WR, 200, 0, 8'h55, 1'b1);
    // record ending at the top of the store, with a surplus byte
    queue_item(fees_pkg::CMD_REC_WR, STORE_LIM - 2, 1, 8'h00, 1'b0);
    queue_item(fees_pkg::CMD_REC_WR, STORE_LIM - 2, 1, 8'hAA, 1'b1);
    // short read, and a read past the store
    queue_item(fees_pkg::CMD_REC_RD, STORE_LIM - 4, 3, 8'h00, 1'b0);
    queue_item(fees_pkg::CMD_REC_RD, STORE_LIM - 4, 3, 8'h00, 1'b1);
    queue_item(fees_pkg::CMD_REC_RD, 4095, 1, 8'h00, 1'b1);

    queue_random(80);
    drain();

    send_idle_pct = 77;
    recv_idle_pct = 17;
    queue_random(80);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(70);
    pressure_phase = 1'b1;
    drain();
    repeat (40) @(posedge clk);

    $display("covered %0d input transfers and %0d checked results", items_accepted,
             results_checked);
    $display("  %0d page erases, %0d record verdicts, %0d dropped records, one long stall",
             erase_seen, verdict_seen, drop_seen);
    if (err_count == 0) begin
      $display("flash_eeprom_emulation_store regression: pass");
    end else begin
      $display("flash_eeprom_emulation_store regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 20);
    $display("timeout with %0d results still awaited", awaited_results.size());
    $display("flash_eeprom_emulation_store regression: fail");
    $finish;
  end

endmodule
